// File: hdl/mshd_pkg.sv
// ----------------------------------------------------------------------------
// mshd_pkg
// Types, widths and constants shared by the magnetometer heading pipeline.
// ----------------------------------------------------------------------------
package mshd_pkg;

   localparam int ROT_STEPS = 16;
   localparam int SHIFT_W   = $clog2(ROT_STEPS);

   localparam int RAW_W   = 16;
   localparam int XY_W    = 39;
   localparam int ANG_W   = 45;
   localparam int TURN_W  = 43;
   localparam int PRE_BITS = 20;

   localparam int MAG_W   = 23;
   localparam int RECIP_W = 24;
   localparam int RECIP_SHIFT = 27;
   localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd14) / 64'd15);
   localparam int FQ_W    = 19;
   localparam int FIELD_W = 20;

   localparam int REM_W   = 58;
   localparam int QUO_W   = 16;
   localparam logic [QUO_W-1:0] HEADING_WRAP = 16'd46080;

   localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_Q40_64 = (PI_Q60 + 64'd524288) >> 20;
   localparam logic signed [ANG_W-1:0] PI_ANG     = ANG_W'(PI_Q40_64);
   localparam logic signed [ANG_W-1:0] TWO_PI_ANG = ANG_W'(PI_Q40_64 << 1);
   localparam logic [REM_W-1:0] PI_REM      = REM_W'(PI_Q40_64);
   localparam logic [REM_W-1:0] HALF_PI_REM = REM_W'(PI_Q40_64 >> 1);

   typedef enum logic [1:0] {
      RC_OK        = 2'd0,
      RC_OVERFLOW  = 2'd1,
      RC_NOT_READY = 2'd2,
      RC_ALL_ZERO  = 2'd3
   } result_code_type;

   localparam int STATUS_READY    = 0;
   localparam int STATUS_OVERFLOW = 1;

   typedef struct packed {
      result_code_type          code;
      logic signed [RAW_W-1:0]  raw_x;
      logic signed [RAW_W-1:0]  raw_y;
      logic signed [RAW_W-1:0]  raw_z;
      logic [MAG_W-1:0]         mag_x;
      logic [MAG_W-1:0]         mag_y;
      logic [MAG_W-1:0]         mag_z;
      logic                     xy_zero;
   } rot_side_type;

   typedef struct packed {
      result_code_type          code;
      logic signed [RAW_W-1:0]  raw_x;
      logic signed [RAW_W-1:0]  raw_y;
      logic signed [RAW_W-1:0]  raw_z;
      logic [FQ_W-1:0]          fq_x;
      logic [FQ_W-1:0]          fq_y;
      logic [FQ_W-1:0]          fq_z;
      logic                     xy_zero;
   } div_side_type;

   // atan(2^-step) in radians * 2^40, from the truncated power series at 2^-60 (pi/4 for step 0)
   function automatic logic signed [ANG_W-1:0] atan_q40(input int step);
      longint signed   sum;
      longint unsigned term;
      longint unsigned rounded;
      int              odd;
      int              e;
      sum = 0;
      rounded = 0;
      if (step == 0) begin
         rounded = ((PI_Q60 >> 2) + 64'd524288) >> 20;
      end else begin
         for (int k = 0; k < 64; k++) begin
            odd = 2 * k + 1;
            e = 60 - step * odd;
            if (e >= 0) begin
               term = (64'd1 << e) / 64'(odd);
               if (k[0]) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
         end
         rounded = (64'(unsigned'(sum)) + 64'd524288) >> 20;
      end
      return ANG_W'(rounded);
   endfunction

endpackage

// File: hdl/magnetometer_sample_heading_core.sv
// ----------------------------------------------------------------------------
// magnetometer_sample_heading_core
// Magnetometer sample decoder with level compass heading.
// ----------------------------------------------------------------------------
// Takes one sample beat per clock unless the result side stalls, and returns one
// result beat per sample, in order. The path runs through a decode stage, 16
// micro-rotation cells, a scaling stage, 16 quotient-bit cells that turn the
// angle into 1/128 degree, and the result register. Every stage moves on the
// same enable, so a stalled result holds the whole row and req_stall follows
// rsp_stall in the same cycle while a result beat is valid. The range register
// is written through csr_range_select and is always ready.
module magnetometer_sample_heading_core import mshd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_status_byte,
   input  logic [7:0]                req_x_low_byte,
   input  logic [7:0]                req_x_high_byte,
   input  logic [7:0]                req_y_low_byte,
   input  logic [7:0]                req_y_high_byte,
   input  logic [7:0]                req_z_low_byte,
   input  logic [7:0]                req_z_high_byte,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_result_code,
   output logic signed [RAW_W-1:0]   rsp_raw_x,
   output logic signed [RAW_W-1:0]   rsp_raw_y,
   output logic signed [RAW_W-1:0]   rsp_raw_z,
   output logic signed [FIELD_W-1:0] rsp_field_x,
   output logic signed [FIELD_W-1:0] rsp_field_y,
   output logic signed [FIELD_W-1:0] rsp_field_z,
   output logic [QUO_W-1:0]          rsp_heading,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_range_select
);

   logic advance;
   logic range_ff;

   logic                    rot_valid [ROT_STEPS+1];
   logic signed [XY_W-1:0]  rot_x     [ROT_STEPS+1];
   logic signed [XY_W-1:0]  rot_y     [ROT_STEPS+1];
   logic signed [ANG_W-1:0] rot_z     [ROT_STEPS+1];
   rot_side_type            rot_side  [ROT_STEPS+1];

   logic                    fin_valid_ff;
   logic [REM_W-1:0]        fin_rem_ff, fin_rem_in;
   div_side_type            fin_side_ff, fin_side_in;
   logic signed [ANG_W-1:0] wrap_z;
   logic [TURN_W-1:0]       turn;
   logic [REM_W-1:0]        turn_ext;
   logic [MAG_W+RECIP_W-1:0] prod_x, prod_y, prod_z;

   logic                    dv_valid [QUO_W+1];
   logic [REM_W-1:0]        dv_rem   [QUO_W+1];
   logic [QUO_W-1:0]        dv_quo   [QUO_W+1];
   div_side_type            dv_side  [QUO_W+1];

   logic                      rsp_valid_ff;
   result_code_type           rsp_code_ff;
   logic signed [RAW_W-1:0]   raw_x_ff, raw_y_ff, raw_z_ff;
   logic signed [FIELD_W-1:0] field_x_ff, field_y_ff, field_z_ff, field_x_in, field_y_in,
                              field_z_in;
   logic [QUO_W-1:0]          heading_ff, heading_in;
   div_side_type              last_side;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         range_ff <= csr_range_select;
      end
   end

   mshd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .range_select (range_ff),
      .in_valid     (req_valid),
      .status_byte  (req_status_byte),
      .x_low_byte   (req_x_low_byte),
      .x_high_byte  (req_x_high_byte),
      .y_low_byte   (req_y_low_byte),
      .y_high_byte  (req_y_high_byte),
      .z_low_byte   (req_z_low_byte),
      .z_high_byte  (req_z_high_byte),
      .out_valid    (rot_valid[0]),
      .out_x        (rot_x[0]),
      .out_y        (rot_y[0]),
      .out_z        (rot_z[0]),
      .out_side     (rot_side[0])
   );

   for (genvar k = 0; k < ROT_STEPS; k++) begin : g_rot
      localparam logic signed [ANG_W-1:0] STEP_ANGLE = atan_q40(k);
      mshd_rotate_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .shift      (SHIFT_W'(k)),
         .step_angle (STEP_ANGLE),
         .in_valid   (rot_valid[k]),
         .in_x       (rot_x[k]),
         .in_y       (rot_y[k]),
         .in_z       (rot_z[k]),
         .in_side    (rot_side[k]),
         .out_valid  (rot_valid[k+1]),
         .out_x      (rot_x[k+1]),
         .out_y      (rot_y[k+1]),
         .out_z      (rot_z[k+1]),
         .out_side   (rot_side[k+1])
      );
   end

   // angle wrap, heading numerator and field scaling by 1/15
   always_comb begin
      wrap_z = rot_z[ROT_STEPS][ANG_W-1] ? rot_z[ROT_STEPS] + TWO_PI_ANG : rot_z[ROT_STEPS];
      turn   = wrap_z[ANG_W-1] ? '0 : wrap_z[TURN_W-1:0];
      turn_ext = REM_W'(turn);
      fin_rem_in = (turn_ext << 14) + (turn_ext << 12) + (turn_ext << 11) + (turn_ext << 9)
                   + HALF_PI_REM;
      prod_x = (MAG_W+RECIP_W)'(rot_side[ROT_STEPS].mag_x) * (MAG_W+RECIP_W)'(RECIP_15);
      prod_y = (MAG_W+RECIP_W)'(rot_side[ROT_STEPS].mag_y) * (MAG_W+RECIP_W)'(RECIP_15);
      prod_z = (MAG_W+RECIP_W)'(rot_side[ROT_STEPS].mag_z) * (MAG_W+RECIP_W)'(RECIP_15);
      fin_side_in.code    = rot_side[ROT_STEPS].code;
      fin_side_in.raw_x   = rot_side[ROT_STEPS].raw_x;
      fin_side_in.raw_y   = rot_side[ROT_STEPS].raw_y;
      fin_side_in.raw_z   = rot_side[ROT_STEPS].raw_z;
      fin_side_in.xy_zero = rot_side[ROT_STEPS].xy_zero;
      fin_side_in.fq_x = FQ_W'(prod_x >> RECIP_SHIFT);
      fin_side_in.fq_y = FQ_W'(prod_y >> RECIP_SHIFT);
      fin_side_in.fq_z = FQ_W'(prod_z >> RECIP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (advance) begin
         fin_valid_ff <= rot_valid[ROT_STEPS];
      end
      if (advance) begin
         fin_rem_ff  <= fin_rem_in;
         fin_side_ff <= fin_side_in;
      end
   end

   assign dv_valid[0] = fin_valid_ff;
   assign dv_rem[0]   = fin_rem_ff;
   assign dv_quo[0]   = '0;
   assign dv_side[0]  = fin_side_ff;

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      localparam logic [REM_W-1:0] DIVISOR = PI_REM << (QUO_W - 1 - k);
      mshd_divide_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .divisor   (DIVISOR),
         .in_valid  (dv_valid[k]),
         .in_rem    (dv_rem[k]),
         .in_quo    (dv_quo[k]),
         .in_side   (dv_side[k]),
         .out_valid (dv_valid[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_quo   (dv_quo[k+1]),
         .out_side  (dv_side[k+1])
      );
   end

   always_comb begin
      last_side = dv_side[QUO_W];
      field_x_in = last_side.raw_x[RAW_W-1] ? -FIELD_W'(last_side.fq_x) : FIELD_W'(last_side.fq_x);
      field_y_in = last_side.raw_y[RAW_W-1] ? -FIELD_W'(last_side.fq_y) : FIELD_W'(last_side.fq_y);
      field_z_in = last_side.raw_z[RAW_W-1] ? -FIELD_W'(last_side.fq_z) : FIELD_W'(last_side.fq_z);
      if (last_side.xy_zero || dv_quo[QUO_W] >= HEADING_WRAP) begin
         heading_in = '0;
      end else begin
         heading_in = dv_quo[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid[QUO_W];
      end
      if (advance) begin
         rsp_code_ff <= last_side.code;
         raw_x_ff    <= last_side.raw_x;
         raw_y_ff    <= last_side.raw_y;
         raw_z_ff    <= last_side.raw_z;
         field_x_ff  <= field_x_in;
         field_y_ff  <= field_y_in;
         field_z_ff  <= field_z_in;
         heading_ff  <= heading_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_code = rsp_code_ff;
   assign rsp_raw_x       = raw_x_ff;
   assign rsp_raw_y       = raw_y_ff;
   assign rsp_raw_z       = raw_z_ff;
   assign rsp_field_x     = field_x_ff;
   assign rsp_field_y     = field_y_ff;
   assign rsp_field_z     = field_z_ff;
   assign rsp_heading     = heading_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_code != RC_OK |->
         rsp_raw_x == '0 && rsp_raw_y == '0 && rsp_raw_z == '0 && rsp_field_x == '0
         && rsp_field_y == '0 && rsp_field_z == '0 && rsp_heading == '0)
      else $error("failed sample beat carries nonzero data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heading < HEADING_WRAP)
      else $error("heading beyond full turn");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_code == RC_OK |->
         (rsp_raw_x == '0) == (rsp_field_x == '0) && (rsp_raw_y == '0) == (rsp_field_y == '0)
         && (rsp_raw_z == '0) == (rsp_field_z == '0))
      else $error("scaled field disagrees with raw reading");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_code == RC_OK |-> rsp_field_x[FIELD_W-1] == rsp_raw_x[RAW_W-1])
      else $error("scaled field sign flipped");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat straight out of reset");

endmodule

// File: hdl/mshd_front.sv
// ----------------------------------------------------------------------------
// mshd_front
// Status check, axis assembly, field magnitude and rotation start vector.
// ----------------------------------------------------------------------------
module mshd_front import mshd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     range_select,
   input  logic                     in_valid,
   input  logic [7:0]               status_byte,
   input  logic [7:0]               x_low_byte,
   input  logic [7:0]               x_high_byte,
   input  logic [7:0]               y_low_byte,
   input  logic [7:0]               y_high_byte,
   input  logic [7:0]               z_low_byte,
   input  logic [7:0]               z_high_byte,
   output logic                     out_valid,
   output logic signed [XY_W-1:0]   out_x,
   output logic signed [XY_W-1:0]   out_y,
   output logic signed [ANG_W-1:0]  out_z,
   output rot_side_type             out_side
);

   logic                    valid_ff;
   logic signed [XY_W-1:0]  x_ff, x_in;
   logic signed [XY_W-1:0]  y_ff, y_in;
   logic signed [ANG_W-1:0] z_ff, z_in;
   rot_side_type            side_ff, side_in;

   logic signed [RAW_W-1:0] rx, ry, rz;
   logic signed [XY_W-1:0]  ext_x, ext_y;

   function automatic logic [MAG_W-1:0] scaled_mag(input logic signed [RAW_W-1:0] raw,
                                                   input logic rng);
      logic signed [RAW_W:0] ext;
      logic [RAW_W:0]        mag;
      ext = {raw[RAW_W-1], raw};
      mag = raw[RAW_W-1] ? (RAW_W+1)'(-ext) : (RAW_W+1)'(ext);
      if (rng) begin
         return MAG_W'({mag, 7'b0});
      end
      return MAG_W'({mag, 5'b0});
   endfunction

   always_comb begin
      rx = signed'({x_high_byte, x_low_byte});
      ry = signed'({y_high_byte, y_low_byte});
      rz = signed'({z_high_byte, z_low_byte});
      ext_x = XY_W'(rx) <<< PRE_BITS;
      ext_y = XY_W'(ry) <<< PRE_BITS;

      side_in = '0;
      x_in = '0;
      y_in = '0;
      z_in = '0;
      if (status_byte[STATUS_OVERFLOW]) begin
         side_in.code = RC_OVERFLOW;
      end else if (!status_byte[STATUS_READY]) begin
         side_in.code = RC_NOT_READY;
      end else if (rx == '0 && ry == '0 && rz == '0) begin
         side_in.code = RC_ALL_ZERO;
      end else begin
         side_in.code = RC_OK;
      end

      if (side_in.code == RC_OK) begin
         side_in.raw_x = rx;
         side_in.raw_y = ry;
         side_in.raw_z = rz;
         side_in.mag_x = scaled_mag(rx, range_select);
         side_in.mag_y = scaled_mag(ry, range_select);
         side_in.mag_z = scaled_mag(rz, range_select);
         side_in.xy_zero = (rx == '0) && (ry == '0);
         if (rx[RAW_W-1]) begin
            x_in = -ext_x;
            y_in = -ext_y;
            z_in = PI_ANG;
         end else begin
            x_in = ext_x;
            y_in = ext_y;
         end
      end else begin
         side_in.xy_zero = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

// File: hdl/mshd_rotate_cell.sv
// ----------------------------------------------------------------------------
// mshd_rotate_cell
// One vectoring micro-rotation stage, carrying the sample's sideband along.
// ----------------------------------------------------------------------------
module mshd_rotate_cell import mshd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [SHIFT_W-1:0]       shift,
   input  logic signed [ANG_W-1:0]  step_angle,
   input  logic                     in_valid,
   input  logic signed [XY_W-1:0]   in_x,
   input  logic signed [XY_W-1:0]   in_y,
   input  logic signed [ANG_W-1:0]  in_z,
   input  rot_side_type             in_side,
   output logic                     out_valid,
   output logic signed [XY_W-1:0]   out_x,
   output logic signed [XY_W-1:0]   out_y,
   output logic signed [ANG_W-1:0]  out_z,
   output rot_side_type             out_side
);

   logic                    valid_ff;
   logic signed [XY_W-1:0]  x_ff, x_in;
   logic signed [XY_W-1:0]  y_ff, y_in;
   logic signed [ANG_W-1:0] z_ff, z_in;
   rot_side_type            side_ff;
   logic signed [XY_W-1:0]  dx, dy;

   always_comb begin
      dx = in_y >>> shift;
      dy = in_x >>> shift;
      if (!in_y[XY_W-1]) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + step_angle;
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

// File: hdl/mshd_divide_cell.sv
// ----------------------------------------------------------------------------
// mshd_divide_cell
// One restoring quotient-bit stage of the angle-to-heading conversion.
// ----------------------------------------------------------------------------
module mshd_divide_cell import mshd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [REM_W-1:0]   divisor,
   input  logic               in_valid,
   input  logic [REM_W-1:0]   in_rem,
   input  logic [QUO_W-1:0]   in_quo,
   input  div_side_type       in_side,
   output logic               out_valid,
   output logic [REM_W-1:0]   out_rem,
   output logic [QUO_W-1:0]   out_quo,
   output div_side_type       out_side
);

   logic               valid_ff;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   div_side_type       side_ff;
   logic               fits;

   always_comb begin
      fits   = in_rem >= divisor;
      rem_in = fits ? in_rem - divisor : in_rem;
      quo_in = {in_quo[QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_side  = side_ff;

endmodule
